// ----- src/hgc_pkg.sv -----
// Shared types, constants and the control program of the hand gesture classifier.
package hgc_pkg;

	localparam int COORD_BITS        = 18;
	localparam int COORD_FRAC_BITS_D = 16;
	localparam int NEAR_BITS         = 16;
	localparam int NEAR_FRAC_BITS    = 16;
	localparam logic [NEAR_BITS-1:0] NEAR_RESET = 16'd3277;
	localparam int SLOT_COUNT        = 12;
	localparam int SLOT_W            = $clog2(SLOT_COUNT);
	localparam int FLAG_COUNT        = 5;
	localparam int FLAG_W            = $clog2(FLAG_COUNT);
	localparam int PC_W              = 6;

	localparam logic [SLOT_W-1:0] SL_WRIST = 4'd0;
	localparam logic [SLOT_W-1:0] SL_P3    = 4'd1;
	localparam logic [SLOT_W-1:0] SL_P4    = 4'd2;
	localparam logic [SLOT_W-1:0] SL_P7    = 4'd3;
	localparam logic [SLOT_W-1:0] SL_P8    = 4'd4;
	localparam logic [SLOT_W-1:0] SL_P9    = 4'd5;
	localparam logic [SLOT_W-1:0] SL_P10   = 4'd6;
	localparam logic [SLOT_W-1:0] SL_P12   = 4'd7;
	localparam logic [SLOT_W-1:0] SL_P14   = 4'd8;
	localparam logic [SLOT_W-1:0] SL_P16   = 4'd9;
	localparam logic [SLOT_W-1:0] SL_P18   = 4'd10;
	localparam logic [SLOT_W-1:0] SL_P20   = 4'd11;

	localparam logic [FLAG_W-1:0] FL_THUMB  = 3'd0;
	localparam logic [FLAG_W-1:0] FL_INDEX  = 3'd1;
	localparam logic [FLAG_W-1:0] FL_MIDDLE = 3'd2;
	localparam logic [FLAG_W-1:0] FL_RING   = 3'd3;
	localparam logic [FLAG_W-1:0] FL_LITTLE = 3'd4;

	localparam logic [PC_W-1:0] PC_DONE = 6'd51;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_BASE_SUM,
		OP_BASE_DBL,
		OP_DIFF,
		OP_MULX,
		OP_MULY,
		OP_SUM_SAVE,
		OP_SUM_CMP,
		OP_SUM_NEAR,
		OP_DONE
	} op_t;

	typedef enum logic [0:0] {
		J_NONE,
		J_NOT_OKAY
	} jmp_t;

	typedef enum logic [2:0] {
		G_NONE     = 3'd0,
		G_THUMB_UP = 3'd1,
		G_PEACE    = 3'd2,
		G_DEVIL    = 3'd3,
		G_OKAY     = 3'd4,
		G_MIDDLE   = 3'd5,
		G_FIST     = 3'd6
	} gesture_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] rd_a;
		logic [SLOT_W-1:0] rd_b;
		logic [FLAG_W-1:0] flag_sel;
		jmp_t              jmp;
		logic [PC_W-1:0]   target;
	} ucode_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] rd_a;
		logic [SLOT_W-1:0] rd_b;
		logic [FLAG_W-1:0] flag_sel;
		logic              wr_en;
		logic [SLOT_W-1:0] wr_slot;
	} dp_ctrl_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} slot_map_t;

	function automatic slot_map_t slot_lookup(input logic [4:0] idx);
		slot_map_t m;
		m.hit = 1'b1;
		m.slot = SL_WRIST;
		case (idx)
			5'd0:  m.slot = SL_WRIST;
			5'd3:  m.slot = SL_P3;
			5'd4:  m.slot = SL_P4;
			5'd7:  m.slot = SL_P7;
			5'd8:  m.slot = SL_P8;
			5'd9:  m.slot = SL_P9;
			5'd10: m.slot = SL_P10;
			5'd12: m.slot = SL_P12;
			5'd14: m.slot = SL_P14;
			5'd16: m.slot = SL_P16;
			5'd18: m.slot = SL_P18;
			5'd20: m.slot = SL_P20;
			default: m.hit = 1'b0;
		endcase
		return m;
	endfunction

	function automatic ucode_t uw(input op_t op, input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b, input logic [FLAG_W-1:0] f);
		ucode_t w;
		w.op = op;
		w.rd_a = a;
		w.rd_b = b;
		w.flag_sel = f;
		w.jmp = J_NONE;
		w.target = '0;
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = uw(OP_NOP, SL_WRIST, SL_WRIST, FL_THUMB);
		case (pc)
			// thumb: doubled midpoint of 9 and 10 against doubled 3 and 4
			6'd0:  w = uw(OP_NOP,      SL_P9,    SL_P10,   FL_THUMB);
			6'd1:  w = uw(OP_BASE_SUM, SL_P3,    SL_WRIST, FL_THUMB);
			6'd2:  w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd3:  w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd4:  w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd5:  w = uw(OP_SUM_SAVE, SL_P4,    SL_WRIST, FL_THUMB);
			6'd6:  w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd7:  w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd8:  w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd9:  w = uw(OP_SUM_CMP,  SL_WRIST, SL_WRIST, FL_THUMB);
			// index: wrist to 7 against wrist to 8
			6'd10: w = uw(OP_BASE_DBL, SL_P7,    SL_WRIST, FL_INDEX);
			6'd11: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_INDEX);
			6'd12: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_INDEX);
			6'd13: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_INDEX);
			6'd14: w = uw(OP_SUM_SAVE, SL_P8,    SL_WRIST, FL_INDEX);
			6'd15: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_INDEX);
			6'd16: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_INDEX);
			6'd17: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_INDEX);
			6'd18: w = uw(OP_SUM_CMP,  SL_WRIST, SL_WRIST, FL_INDEX);
			// middle: wrist to 10 against wrist to 12
			6'd19: w = uw(OP_BASE_DBL, SL_P10,   SL_WRIST, FL_MIDDLE);
			6'd20: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_MIDDLE);
			6'd21: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_MIDDLE);
			6'd22: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_MIDDLE);
			6'd23: w = uw(OP_SUM_SAVE, SL_P12,   SL_WRIST, FL_MIDDLE);
			6'd24: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_MIDDLE);
			6'd25: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_MIDDLE);
			6'd26: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_MIDDLE);
			6'd27: w = uw(OP_SUM_CMP,  SL_WRIST, SL_WRIST, FL_MIDDLE);
			// ring: wrist to 14 against wrist to 16
			6'd28: w = uw(OP_BASE_DBL, SL_P14,   SL_WRIST, FL_RING);
			6'd29: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_RING);
			6'd30: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_RING);
			6'd31: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_RING);
			6'd32: w = uw(OP_SUM_SAVE, SL_P16,   SL_WRIST, FL_RING);
			6'd33: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_RING);
			6'd34: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_RING);
			6'd35: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_RING);
			6'd36: w = uw(OP_SUM_CMP,  SL_WRIST, SL_WRIST, FL_RING);
			// little: wrist to 18 against wrist to 20
			6'd37: w = uw(OP_BASE_DBL, SL_P18,   SL_WRIST, FL_LITTLE);
			6'd38: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_LITTLE);
			6'd39: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_LITTLE);
			6'd40: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_LITTLE);
			6'd41: w = uw(OP_SUM_SAVE, SL_P20,   SL_WRIST, FL_LITTLE);
			6'd42: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_LITTLE);
			6'd43: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_LITTLE);
			6'd44: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_LITTLE);
			6'd45: w = uw(OP_SUM_CMP,  SL_P4,    SL_WRIST, FL_LITTLE);
			// thumb tip to index tip, only when the okay pattern can match
			6'd46: begin
				w = uw(OP_BASE_DBL, SL_P8, SL_WRIST, FL_THUMB);
				w.jmp = J_NOT_OKAY;
				w.target = PC_DONE;
			end
			6'd47: w = uw(OP_DIFF,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd48: w = uw(OP_MULX,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd49: w = uw(OP_MULY,     SL_WRIST, SL_WRIST, FL_THUMB);
			6'd50: w = uw(OP_SUM_NEAR, SL_WRIST, SL_WRIST, FL_THUMB);
			6'd51: w = uw(OP_DONE,     SL_WRIST, SL_WRIST, FL_THUMB);
			default: w = uw(OP_DONE,   SL_WRIST, SL_WRIST, FL_THUMB);
		endcase
		return w;
	endfunction

endpackage

// ----- src/hgc_datapath.sv -----
// Landmark store, squared-distance unit and open-flag registers of the classifier.
module hgc_datapath #(
	parameter int COORD_FRAC_BITS = hgc_pkg::COORD_FRAC_BITS_D
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hgc_pkg::dp_ctrl_t                    ctrl,
	input  logic [hgc_pkg::COORD_BITS-1:0]       wr_x,
	input  logic [hgc_pkg::COORD_BITS-1:0]       wr_y,
	input  logic [hgc_pkg::NEAR_BITS-1:0]        near_distance,
	output logic [hgc_pkg::FLAG_COUNT-1:0]       flags,
	output logic                                 touch
);
	import hgc_pkg::*;

	localparam int BASE_W = COORD_BITS + 2;
	localparam int DIFF_W = COORD_BITS + 3;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int PROD_W = 2 * COORD_BITS + 3;
	localparam int SUM_W  = PROD_W + 1;
	localparam int NSQ_W  = 2 * NEAR_BITS;
	localparam int LSH    = (COORD_FRAC_BITS < NEAR_FRAC_BITS) ?
		2 * (NEAR_FRAC_BITS - COORD_FRAC_BITS) : 0;
	localparam int RSH    = (COORD_FRAC_BITS >= NEAR_FRAC_BITS) ?
		2 * (COORD_FRAC_BITS - NEAR_FRAC_BITS) + 2 : 2;
	localparam int CW     = SUM_W + LSH + RSH;

	logic [2*COORD_BITS-1:0] mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   vld_q;
	logic [2*COORD_BITS-1:0] rda_q, rdb_q;

	logic signed [BASE_W-1:0] bx_q, by_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic [PROD_W-1:0]        prod_q, acc_q;
	logic [SUM_W-1:0]         first_q;
	logic [NSQ_W-1:0]         nsq_q;
	logic [FLAG_COUNT-1:0]    flags_q;
	logic                     touch_q;

	logic signed [BASE_W-1:0] ax, ay, bxv, byv;
	logic signed [DIFF_W-1:0] mul_in;
	logic signed [SQ_W-1:0]   sq_full;
	logic [SUM_W-1:0]         sum;
	logic [CW-1:0]            near_lhs, near_rhs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctrl.wr_en) begin
			vld_q[ctrl.wr_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_slot] <= {wr_y, wr_x};
		end
		rda_q <= vld_q[ctrl.rd_a] ? mem[ctrl.rd_a] : '0;
		rdb_q <= vld_q[ctrl.rd_b] ? mem[ctrl.rd_b] : '0;
	end

	always_comb begin
		ax  = BASE_W'($signed(rda_q[COORD_BITS-1:0]));
		ay  = BASE_W'($signed(rda_q[2*COORD_BITS-1:COORD_BITS]));
		bxv = BASE_W'($signed(rdb_q[COORD_BITS-1:0]));
		byv = BASE_W'($signed(rdb_q[2*COORD_BITS-1:COORD_BITS]));
		mul_in = (ctrl.op == OP_MULY) ? dy_q : dx_q;
		sq_full = mul_in * mul_in;
		sum = SUM_W'(acc_q) + SUM_W'(prod_q);
		near_lhs = CW'(sum) << LSH;
		near_rhs = CW'(nsq_q) << RSH;
	end

	always_ff @(posedge clk) begin
		nsq_q <= NSQ_W'(near_distance) * NSQ_W'(near_distance);
		case (ctrl.op)
			OP_BASE_SUM: begin
				bx_q <= ax + bxv;
				by_q <= ay + byv;
			end
			OP_BASE_DBL: begin
				bx_q <= ax <<< 1;
				by_q <= ay <<< 1;
			end
			OP_DIFF: begin
				dx_q <= DIFF_W'(bx_q) - (DIFF_W'(ax) <<< 1);
				dy_q <= DIFF_W'(by_q) - (DIFF_W'(ay) <<< 1);
			end
			OP_MULX: begin
				prod_q <= sq_full[PROD_W-1:0];
			end
			OP_MULY: begin
				prod_q <= sq_full[PROD_W-1:0];
				acc_q  <= prod_q;
			end
			OP_SUM_SAVE: begin
				first_q <= sum;
			end
			OP_SUM_CMP: begin
				flags_q[ctrl.flag_sel] <= (first_q < sum);
			end
			OP_SUM_NEAR: begin
				touch_q <= (near_lhs < near_rhs);
			end
			default: begin
			end
		endcase
	end

	assign flags = flags_q;
	assign touch = touch_q;

endmodule

// ----- src/hand_gesture_classifier.sv -----
// Top level of the hand gesture classifier: stream ports, microcode sequencer, result register.
//
// Landmarks enter on the s_ channel, one word per landmark: index, x and y in signed
// fixed point, with s_tlast on the final landmark of a hand. Words with an unused index
// are dropped; stored landmarks persist from hand to hand until overwritten.
// A word with s_tlast starts a classification program of 52 steps in a read-only table,
// one open flag every nine or ten steps through a single shared 21 by 21 bit squarer.
// The touch test is skipped when the flags cannot give okay, which saves four steps.
// The result word (gesture, open flags) is registered onto m_ at the final program step, which
// is held only while an earlier result still waits on the receiver;
// s_tready stays low while the program runs and is high otherwise, one landmark per cycle.
// A result waiting on a stalled receiver does not block new landmarks; the next program
// holds at its final step until the result register is free.
// cfg_wen writes near_distance; write only while no classification is under way.
// Reset clears the landmark store to zero, near_distance to 3277 and empties the output.
module hand_gesture_classifier #(
	parameter int COORD_FRAC_BITS = hgc_pkg::COORD_FRAC_BITS_D
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [47:0]                   s_tdata,   // point_index, coord_x, coord_y
	input  logic                          s_tlast,   // last_point
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // gesture, open_mask
	input  logic                          cfg_wen,
	input  logic [hgc_pkg::NEAR_BITS-1:0] cfg_wdata
);
	import hgc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                state_q;
	logic [PC_W-1:0]       pc_q;
	logic [NEAR_BITS-1:0]  near_q;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;

	ucode_t                word;
	dp_ctrl_t              ctrl;
	slot_map_t             smap;
	logic                  accept;
	logic                  out_free;
	logic                  result_load;
	logic                  okay_shape;
	logic [FLAG_COUNT-1:0] flags;
	logic                  touch;
	gesture_t              gesture;

	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign word        = ucode_rom(pc_q);
	assign smap        = slot_lookup(s_tdata[4:0]);
	assign result_load = (state_q == ST_RUN) && (word.op == OP_DONE) && out_free;

	always_comb begin
		ctrl.op       = (state_q == ST_RUN) ? word.op : OP_NOP;
		ctrl.rd_a     = word.rd_a;
		ctrl.rd_b     = word.rd_b;
		ctrl.flag_sel = word.flag_sel;
		ctrl.wr_en    = accept && smap.hit;
		ctrl.wr_slot  = smap.slot;
	end

	hgc_datapath #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.wr_x         (s_tdata[22:5]),
		.wr_y         (s_tdata[40:23]),
		.near_distance(near_q),
		.flags        (flags),
		.touch        (touch)
	);

	always_comb begin
		okay_shape = !flags[FL_INDEX] && flags[FL_MIDDLE] && flags[FL_RING] &&
			flags[FL_LITTLE];
		if (flags == 5'b00001) begin
			gesture = G_THUMB_UP;
		end else if (flags == 5'b00110) begin
			gesture = G_PEACE;
		end else if (flags == 5'b10010) begin
			gesture = G_DEVIL;
		end else if (okay_shape && touch) begin
			gesture = G_OKAY;
		end else if (flags[4:1] == 4'b0010) begin
			gesture = G_MIDDLE;
		end else if (flags == 5'b00000) begin
			gesture = G_FIST;
		end else begin
			gesture = G_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RESET;
		end else if (cfg_wen) begin
			near_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pc_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (result_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tlast) begin
						state_q <= ST_RUN;
						pc_q    <= '0;
					end
				end
				ST_RUN: begin
					if (word.op == OP_DONE) begin
						if (out_free) begin
							state_q <= ST_IDLE;
							pc_q    <= '0;
						end
					end else if (word.jmp == J_NOT_OKAY && !okay_shape) begin
						pc_q <= word.target;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					pc_q    <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			m_tdata_q <= {flags, gesture};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the hand gesture classifier: landmark streams against a gesture predictor.
`timescale 1ns / 100ps

module testbench;

	import hgc_pkg::*;

	localparam int COORD_FRAC     = COORD_FRAC_BITS_D;
	localparam int SHIFT_UP       = (COORD_FRAC >= NEAR_FRAC_BITS) ? 2 * (COORD_FRAC - NEAR_FRAC_BITS) : 0;
	localparam int SHIFT_DN       = (NEAR_FRAC_BITS > COORD_FRAC) ? 2 * (NEAR_FRAC_BITS - COORD_FRAC) : 0;
	localparam int SETTLE_CYCLES  = 64;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int COORD_MAX      = 131071;
	localparam int COORD_MIN      = -131072;

	typedef struct {
		gesture_t       gesture;
		logic [4:0]     open_mask;
	} gesture_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [47:0]          s_tdata = '0;   // point_index, coord_x, coord_y
	logic                 s_tlast = 1'b0; // last_point
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;        // gesture, open_mask
	logic                 cfg_wen = 1'b0;
	logic [NEAR_BITS-1:0] cfg_wdata = '0;

	gesture_word_t        expected_gestures[$];
	logic signed [17:0]   store_x [SLOT_COUNT];
	logic signed [17:0]   store_y [SLOT_COUNT];
	logic [NEAR_BITS-1:0] near_setting;
	int                   hand_x [21];
	int                   hand_y [21];

	int                   src_idle_pct = 0;
	int                   rx_stall_pct = 0;
	logic                 rx_hold_req = 1'b0;
	int                   rx_hold_left = 0;
	int                   quiet_cycles = 0;
	int                   error_count = 0;
	int                   words_sent = 0;
	int                   hands_sent = 0;

	hand_gesture_classifier #(
		.COORD_FRAC_BITS(COORD_FRAC)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int slot_for(input logic [4:0] idx);
		case (idx)
			5'd0:    return 0;
			5'd3:    return 1;
			5'd4:    return 2;
			5'd7:    return 3;
			5'd8:    return 4;
			5'd9:    return 5;
			5'd10:   return 6;
			5'd12:   return 7;
			5'd14:   return 8;
			5'd16:   return 9;
			5'd18:   return 10;
			5'd20:   return 11;
			default: return -1;
		endcase
	endfunction

	function automatic longint sq_span(input longint ax, input longint ay,
		input longint bx, input longint by);
		longint dx;
		longint dy;
		dx = ax - bx;
		dy = ay - by;
		return dx * dx + dy * dy;
	endfunction

	function automatic longint lm_x(input int lm);
		return longint'(store_x[slot_for(5'(lm))]);
	endfunction

	function automatic longint lm_y(input int lm);
		return longint'(store_y[slot_for(5'(lm))]);
	endfunction

	function automatic logic stored_finger_open(input int joint, input int tip);
		return sq_span(lm_x(0), lm_y(0), lm_x(joint), lm_y(joint))
			< sq_span(lm_x(0), lm_y(0), lm_x(tip), lm_y(tip));
	endfunction

	task automatic predict_landmark(input logic [4:0] idx, input logic [17:0] x,
		input logic [17:0] y, input logic is_last);
		int            slot;
		longint        mx;
		longint        my;
		longint        d2;
		longint        near2;
		logic          thumb;
		logic          f1;
		logic          f2;
		logic          f3;
		logic          f4;
		logic          touch;
		gesture_word_t w;
		slot = slot_for(idx);
		if (slot >= 0) begin
			store_x[slot] = x;
			store_y[slot] = y;
		end
		if (is_last) begin
			mx = lm_x(9) + lm_x(10);
			my = lm_y(9) + lm_y(10);
			thumb = sq_span(mx, my, 2 * lm_x(3), 2 * lm_y(3))
				< sq_span(mx, my, 2 * lm_x(4), 2 * lm_y(4));
			f1 = stored_finger_open(7, 8);
			f2 = stored_finger_open(10, 12);
			f3 = stored_finger_open(14, 16);
			f4 = stored_finger_open(18, 20);
			d2 = sq_span(lm_x(4), lm_y(4), lm_x(8), lm_y(8));
			near2 = longint'(near_setting) * longint'(near_setting);
			if (COORD_FRAC >= NEAR_FRAC_BITS)
				touch = d2 < (near2 << SHIFT_UP);
			else
				touch = (d2 << SHIFT_DN) < near2;
			if (thumb && !f1 && !f2 && !f3 && !f4)
				w.gesture = G_THUMB_UP;
			else if (!thumb && f1 && f2 && !f3 && !f4)
				w.gesture = G_PEACE;
			else if (!thumb && f1 && !f2 && !f3 && f4)
				w.gesture = G_DEVIL;
			else if (!f1 && f2 && f3 && f4 && touch)
				w.gesture = G_OKAY;
			else if (!f1 && f2 && !f3 && !f4)
				w.gesture = G_MIDDLE;
			else if (!thumb && !f1 && !f2 && !f3 && !f4)
				w.gesture = G_FIST;
			else
				w.gesture = G_NONE;
			w.open_mask = {f4, f3, f2, f1, thumb};
			expected_gestures.insert(expected_gestures.size(), w);
		end
	endtask

	task automatic send_word(input logic [4:0] idx, input logic [17:0] x,
		input logic [17:0] y, input logic is_last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, y, x, idx};
		s_tlast <= is_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_landmark(idx, x, y, is_last);
		if (is_last || slot_for(idx) >= 0)
			words_sent++;
		if (is_last)
			hands_sent++;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_gestures.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_near(input logic [NEAR_BITS-1:0] value);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		near_setting = value;
	endtask

	task automatic set_idling(input int src_pct, input int rx_pct);
		src_idle_pct = src_pct;
		rx_stall_pct <= rx_pct;
	endtask

	function automatic int rand_between(input int lo, input int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int clip18(input int v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	function automatic logic hand_finger_open(input int joint, input int tip);
		return sq_span(hand_x[0], hand_y[0], hand_x[joint], hand_y[joint])
			< sq_span(hand_x[0], hand_y[0], hand_x[tip], hand_y[tip]);
	endfunction

	function automatic logic hand_thumb_open();
		longint mx;
		longint my;
		mx = longint'(hand_x[9]) + longint'(hand_x[10]);
		my = longint'(hand_y[9]) + longint'(hand_y[10]);
		return sq_span(mx, my, 2 * hand_x[3], 2 * hand_y[3])
			< sq_span(mx, my, 2 * hand_x[4], 2 * hand_y[4]);
	endfunction

	task automatic swap_points(input int a, input int b);
		int tx;
		int ty;
		tx = hand_x[a];
		ty = hand_y[a];
		hand_x[a] = hand_x[b];
		hand_y[a] = hand_y[b];
		hand_x[b] = tx;
		hand_y[b] = ty;
	endtask

	task automatic send_hand(input logic [4:0] want_mask, input bit want_touch);
		int   order [21];
		bit   skip [21];
		int   i;
		int   k;
		int   tmp;
		int   f;
		int   joint;
		int   tip;
		int   span;
		int   cx;
		int   cy;
		int   dx;
		bit   thin_out;
		case ($urandom_range(3))
			0:       span = 1500;
			1:       span = 20000;
			2:       span = 60000;
			default: span = COORD_MAX;
		endcase
		cx = rand_between(-40000, 40000);
		cy = rand_between(-40000, 40000);
		for (i = 0; i < 21; i++) begin
			hand_x[i] = clip18(cx + rand_between(-span, span));
			hand_y[i] = clip18(cy + rand_between(-span, span));
		end
		for (f = 1; f <= 4; f++) begin
			joint = (f == 1) ? 7 : (f == 2) ? 10 : (f == 3) ? 14 : 18;
			tip = (f == 1) ? 8 : (f == 2) ? 12 : (f == 3) ? 16 : 20;
			if (hand_finger_open(joint, tip) != want_mask[f])
				swap_points(joint, tip);
		end
		if (want_touch) begin
			case ($urandom_range(2))
				0:       dx = int'(near_setting) - 1;
				1:       dx = int'(near_setting);
				default: dx = rand_between(0, int'(near_setting));
			endcase
			if ($urandom_range(1))
				dx = -dx;
			hand_x[4] = clip18(hand_x[8] + dx);
			hand_y[4] = hand_y[8];
		end else if (hand_thumb_open() != want_mask[0]) begin
			swap_points(3, 4);
		end
		for (i = 0; i < 21; i++)
			order[i] = i;
		if ($urandom_range(3) == 0) begin
			for (i = 20; i > 0; i--) begin
				k = $urandom_range(i);
				tmp = order[i];
				order[i] = order[k];
				order[k] = tmp;
			end
		end
		thin_out = ($urandom_range(6) == 0);
		for (i = 0; i < 21; i++)
			skip[i] = thin_out && (i != 20) && ($urandom_range(3) == 0);
		for (i = 0; i < 21; i++)
			if (!skip[i])
				send_word(5'(order[i]), 18'(hand_x[order[i]]), 18'(hand_y[order[i]]), i == 20);
	endtask

	task automatic send_noise();
		int n;
		int i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			send_word(5'($urandom_range(31)), 18'($urandom), 18'($urandom),
				(i == n - 1) && ($urandom_range(1) == 1));
	endtask

	task automatic send_random_hand();
		logic [4:0] pattern;
		bit         touch;
		touch = ($urandom_range(9) == 0);
		case ($urandom_range(7))
			0:       pattern = 5'b00001;
			1:       pattern = 5'b00110;
			2:       pattern = 5'b10010;
			3: begin
				pattern = {4'b1110, 1'($urandom)};
				touch = ($urandom_range(3) != 0);
			end
			4:       pattern = {4'b0010, 1'($urandom)};
			5:       pattern = 5'b00000;
			default: pattern = 5'($urandom);
		endcase
		send_hand(pattern, touch);
	endtask

	task automatic test_reset_state();
		send_word(5'd21, 18'h2AAAA, 18'h15555, 1'b1);
		send_word(5'd12, 18'd2000, 18'd0, 1'b0);
		send_word(5'd16, 18'd2000, 18'd0, 1'b0);
		send_word(5'd20, 18'd3000, 18'd0, 1'b0);
		send_word(5'd4, 18'd3277, 18'd0, 1'b1);
		send_word(5'd4, 18'd3276, 18'd0, 1'b1);
		send_word(5'd12, 18'd0, 18'd0, 1'b0);
		send_word(5'd16, 18'd0, 18'd0, 1'b0);
		send_word(5'd20, 18'd0, 18'd0, 1'b0);
		send_word(5'd4, 18'd0, 18'd0, 1'b1);
	endtask

	task automatic test_each_gesture();
		send_word(5'd4, 18'd1000, 18'd0, 1'b1);
		send_word(5'd4, 18'd0, 18'd0, 1'b0);
		send_word(5'd8, 18'd2000, 18'd0, 1'b0);
		send_word(5'd12, 18'd2000, 18'd500, 1'b1);
		send_word(5'd12, 18'd0, 18'd0, 1'b0);
		send_word(5'd20, 18'd3000, 18'd0, 1'b1);
		send_word(5'd8, 18'd0, 18'd0, 1'b0);
		send_word(5'd12, 18'd2000, 18'd0, 1'b0);
		send_word(5'd16, 18'd2000, 18'd0, 1'b1);
		send_word(5'd16, 18'd0, 18'd0, 1'b0);
		send_word(5'd20, 18'd0, 18'd0, 1'b1);
		send_word(5'd12, 18'd0, 18'd0, 1'b1);
		send_word(5'd8, 18'h1FFFF, 18'h20000, 1'b0);
		send_word(5'd16, 18'h20000, 18'h1FFFF, 1'b1);
		send_word(5'd1, 18'h3FFFF, 18'h3FFFF, 1'b0);
		send_word(5'd31, 18'h3FFFF, 18'h00000, 1'b1);
	endtask

	task automatic test_near_distance();
		logic [NEAR_BITS-1:0] values [4];
		int                   i;
		int                   n;
		values[0] = 16'h0000;
		values[1] = 16'hFFFF;
		values[2] = 16'h0001;
		values[3] = 16'($urandom);
		for (i = 0; i < 4; i++) begin
			wait_idle();
			write_near(values[i]);
			for (n = 0; n < 3; n++)
				send_hand({4'b1110, 1'($urandom)}, 1'b1);
		end
	endtask

	task automatic test_random_hands();
		int phase;
		int word_goal;
		int hand_goal;
		for (phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					set_idling(0, 0);
					write_near(16'($urandom));
				end
				1: begin
					set_idling(71, 0);
					write_near(16'hFFFF);
				end
				2: begin
					set_idling(0, 71);
					write_near(16'($urandom_range(4000)));
				end
				default: begin
					set_idling(33, 33);
					write_near(NEAR_RESET);
				end
			endcase
			word_goal = words_sent + 70;
			hand_goal = hands_sent + 6;
			while (words_sent < word_goal || hands_sent < hand_goal) begin
				if ($urandom_range(4) == 0)
					send_noise();
				else
					send_random_hand();
			end
		end
	endtask

	task automatic test_backpressure();
		int n;
		wait_idle();
		set_idling(0, 0);
		rx_hold_req <= 1'b1;
		@(posedge clk);
		rx_hold_req <= 1'b0;
		for (n = 0; n < 3; n++)
			send_random_hand();
		wait_drain();
		send_random_hand();
	endtask

	always @(posedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left <= RX_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		gesture_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_gestures.size() == 0) begin
				$error("unexpected result word: gesture %0d, open_mask %0d",
					m_tdata[2:0], m_tdata[7:3]);
				error_count++;
			end else begin
				w = expected_gestures.pop_front();
				if (m_tdata[2:0] !== w.gesture) begin
					$error("gesture: expected %0d, got %0d", w.gesture, m_tdata[2:0]);
					error_count++;
				end
				if (m_tdata[7:3] !== w.open_mask) begin
					$error("open_mask: expected %0d, got %0d", w.open_mask, m_tdata[7:3]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			store_x[i] = '0;
			store_y[i] = '0;
		end
		near_setting = NEAR_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_each_gesture();
		test_near_distance();
		test_backpressure();
		test_random_hands();
		wait_idle();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
